// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TBMS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TBMS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/tbms_pkg.sv =====
// ----------------------------------------------------------------------------
// tbms_pkg
// types and constants of the time-of-flight beta and momentum selection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbms_pkg;

   // light speed, 0.1 mm per ps in Q16
   localparam logic [17:0] LIGHT_Q16       = 18'd196472;
   localparam logic [15:0] PION_MASS_Q16   = 16'd9147;
   localparam logic [15:0] PROTON_MASS_Q16 = 16'd61491;
   localparam logic [23:0] QP_MAX          = 24'h7FFFFF;
   localparam logic [23:0] QP_MIN          = 24'h800000;
   localparam logic [16:0] BETA_ONE        = 17'h10000;
   localparam logic [16:0] BETA_HIGH_RESET = 17'h10000;

   typedef enum logic [2:0] {
      ST_SELECTED  = 3'd0,
      ST_NO_HIT    = 3'd1,
      ST_NEG_TIME  = 3'd2,
      ST_ABOVE_ONE = 3'd3,
      ST_WINDOW    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_ORIGIN_Z    = 3'd2,
      CSR_T_OFFSET    = 3'd3,
      CSR_PION_LOW    = 3'd4,
      CSR_PION_HIGH   = 3'd5,
      CSR_PROTON_LOW  = 3'd6,
      CSR_PROTON_HIGH = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic               has_tof_hit;
      logic signed [19:0] hit_x;
      logic signed [19:0] hit_y;
      logic signed [19:0] hit_z;
      logic signed [39:0] hit_time;
      logic signed [39:0] event_start;
      logic               species;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic        [16:0] beta;
      logic signed [23:0] q_over_p;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/tbms_isqrt.sv =====
// ----------------------------------------------------------------------------
// tbms_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbms_isqrt #(
   parameter int RootW = 29,
   parameter int SideW = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [2*RootW-1:0]   in_rad,
   input  wire logic [SideW-1:0]     in_side,
   output logic                      out_valid,
   output logic      [RootW-1:0]     out_root,
   output logic      [SideW-1:0]     out_side
);

   localparam int RadW = 2 * RootW;
   localparam int RemW = RootW + 3;

   logic             valid_ff [RootW];
   logic [RadW-1:0]  rad_ff   [RootW];
   logic [RemW-1:0]  rem_ff   [RootW];
   logic [RootW-1:0] root_ff  [RootW];
   logic [SideW-1:0] side_ff  [RootW];

   logic [RadW-1:0]  rad_in   [RootW];
   logic [RemW-1:0]  rem_in   [RootW];
   logic [RootW-1:0] root_in  [RootW];

   logic             p_valid  [RootW+1];
   logic [RadW-1:0]  p_rad    [RootW+1];
   logic [RemW-1:0]  p_rem    [RootW+1];
   logic [RootW-1:0] p_root   [RootW+1];
   logic [SideW-1:0] p_side   [RootW+1];

   assign p_valid[0] = in_valid;
   assign p_rad[0]   = in_rad;
   assign p_rem[0]   = '0;
   assign p_root[0]  = '0;
   assign p_side[0]  = in_side;

   for (genvar g = 0; g < RootW; g++) begin : g_stage
      logic [RemW-1:0] rem_sh;
      logic [RemW-1:0] trial;
      logic            take;

      always_comb begin
         rem_sh     = {p_rem[g][RemW-3:0], p_rad[g][RadW-1 -: 2]};
         trial      = {1'b0, p_root[g], 2'b01};
         take       = (rem_sh >= trial);
         rem_in[g]  = take ? (rem_sh - trial) : rem_sh;
         root_in[g] = {p_root[g][RootW-2:0], take};
         rad_in[g]  = {p_rad[g][RadW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= p_valid[g];
         end
         rad_ff[g]  <= rad_in[g];
         rem_ff[g]  <= rem_in[g];
         root_ff[g] <= root_in[g];
         side_ff[g] <= p_side[g];
      end

      assign p_valid[g+1] = valid_ff[g];
      assign p_rad[g+1]   = rad_ff[g];
      assign p_rem[g+1]   = rem_ff[g];
      assign p_root[g+1]  = root_ff[g];
      assign p_side[g+1]  = side_ff[g];
   end

   assign out_valid = p_valid[RootW];
   assign out_root  = p_root[RootW];
   assign out_side  = p_side[RootW];

endmodule

`default_nettype wire

// ===== design/tbms_div.sv =====
// ----------------------------------------------------------------------------
// tbms_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbms_div #(
   parameter int QuoW  = 17,
   parameter int DivW  = 59,
   parameter int SideW = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   // numerator must be below divisor shifted up by QuoW
   input  wire logic [DivW+QuoW-1:0]   in_num,
   input  wire logic [DivW-1:0]        in_div,
   input  wire logic [SideW-1:0]       in_side,
   output logic                        out_valid,
   output logic      [QuoW-1:0]        out_quo,
   output logic      [SideW-1:0]       out_side
);

   logic             valid_ff [QuoW];
   logic [DivW-1:0]  rem_ff   [QuoW];
   logic [QuoW-1:0]  lo_ff    [QuoW];
   logic [DivW-1:0]  div_ff   [QuoW];
   logic [SideW-1:0] side_ff  [QuoW];

   logic [DivW-1:0]  rem_in   [QuoW];
   logic [QuoW-1:0]  lo_in    [QuoW];

   logic             p_valid  [QuoW+1];
   logic [DivW-1:0]  p_rem    [QuoW+1];
   logic [QuoW-1:0]  p_lo     [QuoW+1];
   logic [DivW-1:0]  p_div    [QuoW+1];
   logic [SideW-1:0] p_side   [QuoW+1];

   assign p_valid[0] = in_valid;
   assign p_rem[0]   = in_num[DivW+QuoW-1:QuoW];
   assign p_lo[0]    = in_num[QuoW-1:0];
   assign p_div[0]   = in_div;
   assign p_side[0]  = in_side;

   for (genvar g = 0; g < QuoW; g++) begin : g_stage
      logic [DivW:0] rem_sh;
      logic [DivW:0] diff;
      logic          take;

      always_comb begin
         rem_sh    = {p_rem[g], p_lo[g][QuoW-1]};
         diff      = rem_sh - {1'b0, p_div[g]};
         take      = (rem_sh >= {1'b0, p_div[g]});
         rem_in[g] = take ? diff[DivW-1:0] : rem_sh[DivW-1:0];
         lo_in[g]  = {p_lo[g][QuoW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= p_valid[g];
         end
         rem_ff[g]  <= rem_in[g];
         lo_ff[g]   <= lo_in[g];
         div_ff[g]  <= p_div[g];
         side_ff[g] <= p_side[g];
      end

      assign p_valid[g+1] = valid_ff[g];
      assign p_rem[g+1]   = rem_ff[g];
      assign p_lo[g+1]    = lo_ff[g];
      assign p_div[g+1]   = div_ff[g];
      assign p_side[g+1]  = side_ff[g];
   end

   assign out_valid = p_valid[QuoW];
   assign out_quo   = p_lo[QuoW];
   assign out_side  = p_side[QuoW];

endmodule

`default_nettype wire

// ===== design/tof_beta_momentum_select.sv =====
// ----------------------------------------------------------------------------
// tof_beta_momentum_select
// time-of-flight beta, charge over momentum and species beta window per track
// ----------------------------------------------------------------------------
// a track taken on start passes, in order, the 3 front stages, the 29-stage root,
// stage a, the 17-stage divide, stage b, the 32-stage root, stages c and d, the
// 24-stage divide and the output register, which drives the result strobe
// throughput: one track per cycle; busy stays low, every start is a beat
// reset: clears every pipeline valid bit and loads the register reset values
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tof_beta_momentum_select (
   input  wire logic              clock,
   input  wire logic              reset,
   // track input
   input  wire logic              start,
   output logic                   busy,
   input  wire tbms_pkg::req_type req_data,
   // result output, one strobe per track
   output logic                   rsp_strobe,
   output tbms_pkg::rsp_type      rsp_data,
   // register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [4:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   logic signed [19:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [31:0] t_offset_ff;
   logic        [16:0] pion_low_ff, pion_high_ff, proton_low_ff, proton_high_ff;
   logic               csr_wr;
   tbms_pkg::csr_index_type csr_idx;

   assign pready  = 1'b1;
   assign busy    = 1'b0;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = tbms_pkg::csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         origin_z_ff    <= '0;
         t_offset_ff    <= '0;
         pion_low_ff    <= '0;
         pion_high_ff   <= tbms_pkg::BETA_HIGH_RESET;
         proton_low_ff  <= '0;
         proton_high_ff <= tbms_pkg::BETA_HIGH_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            tbms_pkg::CSR_ORIGIN_X:    origin_x_ff    <= pwdata[19:0];
            tbms_pkg::CSR_ORIGIN_Y:    origin_y_ff    <= pwdata[19:0];
            tbms_pkg::CSR_ORIGIN_Z:    origin_z_ff    <= pwdata[19:0];
            tbms_pkg::CSR_T_OFFSET:    t_offset_ff    <= pwdata;
            tbms_pkg::CSR_PION_LOW:    pion_low_ff    <= pwdata[16:0];
            tbms_pkg::CSR_PION_HIGH:   pion_high_ff   <= pwdata[16:0];
            tbms_pkg::CSR_PROTON_LOW:  proton_low_ff  <= pwdata[16:0];
            tbms_pkg::CSR_PROTON_HIGH: proton_high_ff <= pwdata[16:0];
         endcase
      end
   end

   // read back, signed registers sign extended
   always_comb begin
      unique case (csr_idx)
         tbms_pkg::CSR_ORIGIN_X:    prdata = {{12{origin_x_ff[19]}}, origin_x_ff};
         tbms_pkg::CSR_ORIGIN_Y:    prdata = {{12{origin_y_ff[19]}}, origin_y_ff};
         tbms_pkg::CSR_ORIGIN_Z:    prdata = {{12{origin_z_ff[19]}}, origin_z_ff};
         tbms_pkg::CSR_T_OFFSET:    prdata = t_offset_ff;
         tbms_pkg::CSR_PION_LOW:    prdata = {15'b0, pion_low_ff};
         tbms_pkg::CSR_PION_HIGH:   prdata = {15'b0, pion_high_ff};
         tbms_pkg::CSR_PROTON_LOW:  prdata = {15'b0, proton_low_ff};
         tbms_pkg::CSR_PROTON_HIGH: prdata = {15'b0, proton_high_ff};
      endcase
   end

   // ------------------------------------------------------------------------
   // stage 1: offsets from the origin and flight time
   // ------------------------------------------------------------------------
   logic               s1_valid_ff;
   logic               s1_hit_ff, s1_species_ff;
   logic signed [20:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic signed [20:0] s1_dx_in, s1_dy_in, s1_dz_in;
   logic signed [41:0] s1_t_ff, s1_t_in;

   always_comb begin
      s1_dx_in = {req_data.hit_x[19], req_data.hit_x} - {origin_x_ff[19], origin_x_ff};
      s1_dy_in = {req_data.hit_y[19], req_data.hit_y} - {origin_y_ff[19], origin_y_ff};
      s1_dz_in = {req_data.hit_z[19], req_data.hit_z} - {origin_z_ff[19], origin_z_ff};
      // 42 bits hold the full difference without wrap
      s1_t_in  = {{2{req_data.hit_time[39]}}, req_data.hit_time}
               - {{2{req_data.event_start[39]}}, req_data.event_start}
               - {{10{t_offset_ff[31]}}, t_offset_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_hit_ff     <= req_data.has_tof_hit;
      s1_species_ff <= req_data.species;
      s1_dx_ff      <= s1_dx_in;
      s1_dy_ff      <= s1_dy_in;
      s1_dz_ff      <= s1_dz_in;
      s1_t_ff       <= s1_t_in;
   end

   // ------------------------------------------------------------------------
   // stage 2: squares, light-time partial products, early status
   // ------------------------------------------------------------------------
   logic                 s2_valid_ff, s2_species_ff;
   logic [40:0]          s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   logic [41:0]          s2_sqx_full, s2_sqy_full, s2_sqz_full;
   // flight time split in a low 21-bit and a high 20-bit half
   logic [38:0]          s2_den_lo_ff, s2_den_lo_in;
   logic [37:0]          s2_den_hi_ff, s2_den_hi_in;
   tbms_pkg::status_type s2_status_ff, s2_status_in;

   always_comb begin
      s2_sqx_full  = s1_dx_ff * s1_dx_ff;
      s2_sqy_full  = s1_dy_ff * s1_dy_ff;
      s2_sqz_full  = s1_dz_ff * s1_dz_ff;
      s2_den_lo_in = s1_t_ff[20:0] * tbms_pkg::LIGHT_Q16;
      s2_den_hi_in = s1_t_ff[40:21] * tbms_pkg::LIGHT_Q16;
      priority if (!s1_hit_ff) begin
         s2_status_in = tbms_pkg::ST_NO_HIT;
      end else if (s1_t_ff[41]) begin
         s2_status_in = tbms_pkg::ST_NEG_TIME;
      end else if (s1_t_ff == '0) begin
         // zero flight time counts as unphysical beta
         s2_status_in = tbms_pkg::ST_ABOVE_ONE;
      end else begin
         s2_status_in = tbms_pkg::ST_SELECTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_species_ff <= s1_species_ff;
      s2_sqx_ff     <= s2_sqx_full[40:0];
      s2_sqy_ff     <= s2_sqy_full[40:0];
      s2_sqz_ff     <= s2_sqz_full[40:0];
      s2_den_lo_ff  <= s2_den_lo_in;
      s2_den_hi_ff  <= s2_den_hi_in;
      s2_status_ff  <= s2_status_in;
   end

   // ------------------------------------------------------------------------
   // stage 3: squared distance, light-time product
   // ------------------------------------------------------------------------
   logic                 s3_valid_ff, s3_species_ff;
   logic [41:0]          s3_r2_ff;
   logic [58:0]          s3_den_ff;
   tbms_pkg::status_type s3_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_species_ff <= s2_species_ff;
      s3_r2_ff      <= {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff} + {1'b0, s2_sqz_ff};
      s3_den_ff     <= {s2_den_hi_ff, 21'b0} + {20'b0, s2_den_lo_ff};
      s3_status_ff  <= s2_status_ff;
   end

   // ------------------------------------------------------------------------
   // distance root: rq = floor(sqrt(r2 * 2^16)), 29 stages
   // ------------------------------------------------------------------------
   logic        rq_valid;
   logic [28:0] rq_root;
   logic [62:0] rq_side;

   tbms_isqrt #(
      .RootW (29),
      .SideW (63)
   ) u_dist_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_rad    ({s3_r2_ff, 16'b0}),
      .in_side   ({s3_status_ff, s3_species_ff, s3_den_ff}),
      .out_valid (rq_valid),
      .out_root  (rq_root),
      .out_side  (rq_side)
   );

   // ------------------------------------------------------------------------
   // stage a: beta above one check
   // ------------------------------------------------------------------------
   logic                 sa_valid_ff, sa_species_ff;
   logic [28:0]          sa_rq_ff;
   logic [58:0]          sa_den_ff;
   tbms_pkg::status_type sa_status_ff, sa_status_in, rq_status;

   always_comb begin
      rq_status = tbms_pkg::status_type'(rq_side[62:60]);
      if (rq_status == tbms_pkg::ST_SELECTED && {22'b0, rq_root, 8'b0} > rq_side[58:0]) begin
         sa_status_in = tbms_pkg::ST_ABOVE_ONE;
      end else begin
         sa_status_in = rq_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= rq_valid;
      end
      sa_species_ff <= rq_side[59];
      sa_rq_ff      <= rq_root;
      sa_den_ff     <= rq_side[58:0];
      sa_status_ff  <= sa_status_in;
   end

   // ------------------------------------------------------------------------
   // beta = floor(rq * 2^24 / den), 17 stages
   // ------------------------------------------------------------------------
   logic        bt_valid;
   logic [16:0] bt_beta;
   logic [3:0]  bt_side;

   tbms_div #(
      .QuoW  (17),
      .DivW  (59),
      .SideW (4)
   ) u_beta_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sa_valid_ff),
      .in_num    ({23'b0, sa_rq_ff, 24'b0}),
      .in_div    (sa_den_ff),
      .in_side   ({sa_status_ff, sa_species_ff}),
      .out_valid (bt_valid),
      .out_quo   (bt_beta),
      .out_side  (bt_side)
   );

   // ------------------------------------------------------------------------
   // stage b: 1 - beta^2 in Q32
   // ------------------------------------------------------------------------
   logic        sb_valid_ff;
   logic [3:0]  sb_side_ff;
   logic [16:0] sb_beta_ff;
   logic [32:0] sb_d_ff;
   logic [33:0] sb_bsq, sb_d_in;

   always_comb begin
      sb_bsq  = bt_beta * bt_beta;
      sb_d_in = 34'h1_0000_0000 - sb_bsq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else begin
         sb_valid_ff <= bt_valid;
      end
      sb_side_ff <= bt_side;
      sb_beta_ff <= bt_beta;
      sb_d_ff    <= sb_d_in[32:0];
   end

   // ------------------------------------------------------------------------
   // s = floor(sqrt(d * 2^30)), Q31, 32 stages
   // ------------------------------------------------------------------------
   logic        sr_valid;
   logic [31:0] sr_root;
   logic [20:0] sr_side;

   tbms_isqrt #(
      .RootW (32),
      .SideW (21)
   ) u_gamma_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sb_valid_ff),
      .in_rad    ({1'b0, sb_d_ff, 30'b0}),
      .in_side   ({sb_side_ff, sb_beta_ff}),
      .out_valid (sr_valid),
      .out_root  (sr_root),
      .out_side  (sr_side)
   );

   // ------------------------------------------------------------------------
   // stage c: divisor beta * mass
   // ------------------------------------------------------------------------
   logic        sc_valid_ff;
   logic [20:0] sc_side_ff;
   logic [31:0] sc_s_ff;
   logic [32:0] sc_divr_ff;
   logic [15:0] sc_mass;

   assign sc_mass = sr_side[17] ? tbms_pkg::PROTON_MASS_Q16 : tbms_pkg::PION_MASS_Q16;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else begin
         sc_valid_ff <= sr_valid;
      end
      sc_side_ff <= sr_side;
      sc_s_ff    <= sr_root;
      sc_divr_ff <= sr_side[16:0] * sc_mass;
   end

   // ------------------------------------------------------------------------
   // stage d: quotient overflow, also covers beta zero
   // ------------------------------------------------------------------------
   logic        sd_valid_ff, sd_ovf_ff;
   logic [20:0] sd_side_ff;
   logic [31:0] sd_s_ff;
   logic [32:0] sd_divr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_valid_ff <= 1'b0;
      end else begin
         sd_valid_ff <= sc_valid_ff;
      end
      sd_side_ff <= sc_side_ff;
      sd_s_ff    <= sc_s_ff;
      sd_divr_ff <= sc_divr_ff;
      // s * 2^17 >= divisor * 2^24 means mag needs more than 24 bits
      sd_ovf_ff  <= ({8'b0, sc_s_ff} >= {sc_divr_ff, 7'b0});
   end

   // ------------------------------------------------------------------------
   // mag = floor(s * 2^17 / (beta * mass)), 24 stages
   // ------------------------------------------------------------------------
   logic        mg_valid;
   logic [23:0] mg_mag;
   logic [21:0] mg_side;

   tbms_div #(
      .QuoW  (24),
      .DivW  (33),
      .SideW (22)
   ) u_mag_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sd_valid_ff),
      .in_num    ({8'b0, sd_s_ff, 17'b0}),
      .in_div    (sd_divr_ff),
      .in_side   ({sd_side_ff, sd_ovf_ff}),
      .out_valid (mg_valid),
      .out_quo   (mg_mag),
      .out_side  (mg_side)
   );

   // ------------------------------------------------------------------------
   // stage e: sign, saturation, window, result register
   // ------------------------------------------------------------------------
   logic                 out_valid_ff;
   tbms_pkg::rsp_type    out_rsp_ff, out_rsp_in;
   tbms_pkg::status_type mg_status;
   logic                 mg_proton, mg_ovf, mg_sat, mg_reject;
   logic [16:0]          mg_beta, mg_low, mg_high;
   logic [23:0]          mg_qp;

   always_comb begin
      mg_status = tbms_pkg::status_type'(mg_side[21:19]);
      mg_proton = mg_side[18];
      mg_beta   = mg_side[17:1];
      mg_ovf    = mg_side[0];
      mg_low    = mg_proton ? proton_low_ff : pion_low_ff;
      mg_high   = mg_proton ? proton_high_ff : pion_high_ff;
      // magnitude at or above 2^23 clips, for a pion exactly 2^23 is the minimum
      mg_sat    = mg_ovf | mg_mag[23];
      if (mg_sat) begin
         mg_qp = mg_proton ? tbms_pkg::QP_MAX : tbms_pkg::QP_MIN;
      end else begin
         mg_qp = mg_proton ? mg_mag : (24'd0 - mg_mag);
      end
      mg_reject = (mg_beta < mg_low) | (mg_beta > mg_high);
      if (mg_status != tbms_pkg::ST_SELECTED) begin
         out_rsp_in.status   = mg_status;
         out_rsp_in.beta     = '0;
         out_rsp_in.q_over_p = '0;
      end else begin
         out_rsp_in.status   = mg_reject ? tbms_pkg::ST_WINDOW : tbms_pkg::ST_SELECTED;
         out_rsp_in.beta     = mg_beta;
         out_rsp_in.q_over_p = mg_qp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= mg_valid;
      end
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_rsp_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // early rejections carry no beta and no momentum
   `TBMS_ASSERT_IMP(a_reject_zero, clock, reset,
      rsp_strobe && rsp_data.status != tbms_pkg::ST_SELECTED
         && rsp_data.status != tbms_pkg::ST_WINDOW,
      rsp_data.beta == '0 && rsp_data.q_over_p == '0)
   // beta of exactly one means zero momentum inverse
   `TBMS_ASSERT_IMP(a_beta_one, clock, reset,
      rsp_strobe && rsp_data.beta == tbms_pkg::BETA_ONE,
      rsp_data.q_over_p == '0)
   // beta zero saturates to either limit (the design picks the sign by species)
   `TBMS_ASSERT_IMP(a_beta_zero, clock, reset,
      rsp_strobe && rsp_data.beta == '0 && (rsp_data.status == tbms_pkg::ST_SELECTED
         || rsp_data.status == tbms_pkg::ST_WINDOW),
      rsp_data.q_over_p == tbms_pkg::QP_MAX || rsp_data.q_over_p == tbms_pkg::QP_MIN)
   // a beat in the front stage always moves on
   `TBMS_ASSERT_NXT(a_front_moves, clock, reset, s1_valid_ff, s2_valid_ff)

endmodule

`default_nettype wire
